FILE: rtl/lpws_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed word search package
// Shared item kinds, queue entry type and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package lpws_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_BYTE = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } q_item_t;

endpackage

`default_nettype wire

FILE: rtl/lpws_if.sv
// ----------------------------------------------------------------------------
// Length-prefixed word search channels
// Valid/ready channel interfaces for items, results and the length register.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpws_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] word_index;
  logic [7:0] data_byte;
  logic       field_last;

  modport source (output valid, cmd, word_index, data_byte, field_last, input ready);
  modport sink   (input valid, cmd, word_index, data_byte, field_last, output ready);
endinterface

interface lpws_out_if;
  logic valid;
  logic ready;
  logic found;
  logic truncated;

  modport source (output valid, found, truncated, input ready);
  modport sink   (input valid, found, truncated, output ready);
endinterface

interface lpws_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] word_length;

  modport source (output valid, word_length, input ready);
  modport sink   (input valid, word_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/length_prefixed_word_search.sv
// ----------------------------------------------------------------------------
// Length-prefixed word search
// Searches streamed fields of length-prefixed records for a stored word.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle when the result side keeps up:
// load items write the word store, field items advance the record state, and
// the last byte of a field gives one result carrying found and truncated.
// Items pass through a four-entry queue into a back end that completes one
// item per cycle unless a result waits unaccepted, bounded by the single
// read and write port of the word store. A result passes through a queue
// entry and then the output register before it is offered. A pending
// result waits in an output register while items keep arriving until the
// queue fills. The word length is written over the configuration channel,
// which is always ready, and is sampled at each record's length byte.
`default_nettype none

module length_prefixed_word_search
  import lpws_pkg::*;
#(
  parameter int WORD_DEPTH = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lpws_in_if.sink    in_ch,
  lpws_out_if.source out_ch,
  lpws_cfg_if.sink   cfg_ch
);

  logic    q_full;
  logic    q_push;
  q_item_t q_push_item;
  logic    q_head_valid;
  q_item_t q_head_item;
  logic    q_pop;

  assign cfg_ch.ready = 1'b1;

  lpws_front #(
    .WORD_DEPTH(WORD_DEPTH)
  ) u_front (
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_cmd        (in_ch.cmd),
    .in_word_index (in_ch.word_index),
    .in_data_byte  (in_ch.data_byte),
    .in_field_last (in_ch.field_last),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_push_item)
  );

  lpws_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_item  (q_head_item),
    .pop        (q_pop)
  );

  lpws_back #(
    .WORD_DEPTH(WORD_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_ch.valid),
    .cfg_word_length (cfg_ch.word_length),
    .head_valid      (q_head_valid),
    .head_item       (q_head_item),
    .pop             (q_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_found       (out_ch.found),
    .out_truncated   (out_ch.truncated)
  );

endmodule

`default_nettype wire

FILE: rtl/lpws_front.sv
// ----------------------------------------------------------------------------
// Length-prefixed word search front end
// Accepts items, drops loads outside the word store and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module lpws_front
  import lpws_pkg::*;
#(
  parameter int WORD_DEPTH = 256
) (
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_word_index,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_field_last,
  input  wire logic       q_full,
  output logic            q_push,
  output q_item_t         q_item
);

  logic keep;

  always_comb begin
    keep        = in_cmd || ({1'b0, in_word_index} < 9'(WORD_DEPTH));
    in_ready    = !q_full;
    q_push      = in_valid && !q_full && keep;
    q_item.op   = in_cmd ? OP_BYTE : OP_LOAD;
    q_item.addr = in_word_index;
    q_item.data = in_data_byte;
    q_item.last = in_field_last;
  end

endmodule

`default_nettype wire

FILE: rtl/lpws_queue.sv
// ----------------------------------------------------------------------------
// Length-prefixed word search queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lpws_queue
  import lpws_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire q_item_t push_item,
  output logic         full,
  output logic         head_valid,
  output q_item_t      head_item,
  input  wire logic    pop
);

  q_item_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;
  logic                do_pop;

  always_comb begin
    full       = (count_r == QCNT_W'(QUEUE_DEPTH));
    head_valid = (count_r != '0);
    head_item  = entry_r[rd_ptr_r];
    do_pop     = pop && head_valid;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lpws_back.sv
// ----------------------------------------------------------------------------
// Length-prefixed word search back end
// Holds the word store and record state, compares field bytes, registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module lpws_back
  import lpws_pkg::*;
#(
  parameter int WORD_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_word_length,
  input  wire logic       head_valid,
  input  wire q_item_t    head_item,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_found,
  output logic            out_truncated
);

  localparam int AW = $clog2(WORD_DEPTH);

  logic [7:0]    mem [WORD_DEPTH];
  logic [7:0]    rd_data_r;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;
  logic [7:0]    store_byte;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;

  logic [7:0] word_length_r;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic       cand_r, cand_nxt;
  logic       seen_r, seen_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       found_r, found_nxt;
  logic       trunc_r, trunc_nxt;
  logic       is_byte;
  logic       pos_ok;
  logic       cand_step;

  always_comb begin
    pop        = head_valid && (!out_valid_r || out_ready);
    is_byte    = (head_item.op == OP_BYTE);
    mem_we     = pop && !is_byte;
    mem_wa     = head_item.addr[AW-1:0];
    store_byte = fwd_r ? fwd_data_r : rd_data_r;
    pos_ok     = ({1'b0, pos_r} < 9'(WORD_DEPTH));
    cand_step  = cand_r && pos_ok && (store_byte == head_item.data);

    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    cand_nxt      = cand_r;
    seen_nxt      = seen_r;
    found_nxt     = found_r;
    trunc_nxt     = trunc_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (pop && is_byte) begin
      if (rem_r == '0) begin
        rem_nxt  = head_item.data;
        pos_nxt  = '0;
        cand_nxt = (head_item.data == word_length_r);
        seen_nxt = seen_r || ((head_item.data == '0) && cand_nxt);
      end else begin
        rem_nxt  = rem_r - 1'b1;
        pos_nxt  = pos_r + 1'b1;
        cand_nxt = cand_step;
        seen_nxt = seen_r || ((rem_nxt == '0) && cand_step);
      end
      if (head_item.last) begin
        out_valid_nxt = 1'b1;
        found_nxt     = seen_nxt;
        trunc_nxt     = (rem_nxt != '0);
        rem_nxt       = '0;
        pos_nxt       = '0;
        cand_nxt      = 1'b0;
        seen_nxt      = 1'b0;
      end
    end

    mem_ra = rst_n ? pos_nxt[AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= head_item.data;
    end
    rd_data_r  <= mem[mem_ra];
    fwd_r      <= mem_we && (mem_wa == mem_ra);
    fwd_data_r <= head_item.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_length_r <= '0;
      rem_r         <= '0;
      pos_r         <= '0;
      cand_r        <= 1'b0;
      seen_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        word_length_r <= cfg_word_length;
      end
      rem_r       <= rem_nxt;
      pos_r       <= pos_nxt;
      cand_r      <= cand_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    trunc_r <= trunc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_found     = found_r;
  assign out_truncated = trunc_r;

endmodule

`default_nettype wire

FILE: verif/length_prefixed_word_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Length-prefixed word search testbench
// Loads search words, streams fields of length-prefixed records and checks
// each found/truncated result against a cycle-free predictor or a typed value.
// A short directed table comes first, then random phases at several word
// lengths, with bursty input, a stalling result side and one long hold-off.
// ----------------------------------------------------------------------------

module length_prefixed_word_search_tb;
  import lpws_pkg::*;

  localparam int STORE_DEPTH  = 256;
  localparam int ITEM_TARGET  = 1850;
  localparam int SETTLE_BOUND = 5000;
  localparam int TAIL_CYCLES  = 12;
  localparam int HOLD_CYCLES  = 80;
  localparam int TIMEOUT_NS   = 5_000_000;

  typedef struct packed {
    op_t        op;
    logic [7:0] word_index;
    logic [7:0] data_byte;
    logic       field_last;
  } search_item_t;

  typedef struct packed {
    logic found;
    logic truncated;
  } search_result_t;

  typedef enum logic [0:0] {
    STEP_ITEM   = 1'b0,
    STEP_LENGTH = 1'b1
  } step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    op_t        op;
    logic [7:0] index;
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic       found;
    logic       truncated;
  } directed_step_t;

  localparam int DIRECTED_COUNT = 31;

  directed_step_t directed_steps [DIRECTED_COUNT] = '{
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h07, 1'b1, 1'b1, 1'b0, 1'b1},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h02, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1},
    '{STEP_ITEM,   OP_LOAD, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_LOAD, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_LOAD, 8'h01, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_LOAD, 8'h02, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_LENGTH, OP_BYTE, 8'h00, 8'h03, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h03, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'hA5, 1'b1, 1'b1, 1'b1, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h03, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'hA5, 1'b1, 1'b1, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h03, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_LOAD, 8'h02, 8'h11, 1'b1, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h11, 1'b1, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h03, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_LENGTH, OP_BYTE, 8'h00, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h11, 1'b1, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0},
    '{STEP_LENGTH, OP_BYTE, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_ITEM,   OP_BYTE, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1}
  };

  logic clk = 1'b0;
  logic rst_n;

  lpws_in_if  in_if ();
  lpws_out_if out_if ();
  lpws_cfg_if cfg_if ();

  length_prefixed_word_search #(
    .WORD_DEPTH(STORE_DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #5 clk = ~clk;

  logic [7:0]     word_mem [STORE_DEPTH];
  bit             word_set [STORE_DEPTH];
  logic [7:0]     length_reg;
  logic [7:0]     remaining;
  logic [7:0]     body_pos;
  bit             candidate;
  bit             matched;

  search_result_t expected_results [$];
  search_item_t   field_items [$];
  int             mismatch_count;
  int             items_sent;
  int             burst_left;
  int             hold_requests;

  function automatic bit predict_search(input search_item_t it, output search_result_t res);
    logic [7:0] stored;
    res = '0;
    if (it.op == OP_LOAD) begin
      if (int'(it.word_index) < STORE_DEPTH) begin
        word_mem[it.word_index] = it.data_byte;
        word_set[it.word_index] = 1'b1;
      end
      return 1'b0;
    end
    if (remaining == 8'd0) begin
      remaining = it.data_byte;
      body_pos  = 8'd0;
      candidate = (it.data_byte == length_reg);
      if (it.data_byte == 8'd0 && candidate) matched = 1'b1;
    end else begin
      if (candidate) begin
        stored = word_set[body_pos] ? word_mem[body_pos] : 8'h00;
        if (int'(body_pos) >= STORE_DEPTH || stored != it.data_byte) candidate = 1'b0;
      end
      body_pos  = body_pos + 8'd1;
      remaining = remaining - 8'd1;
      if (remaining == 8'd0 && candidate) matched = 1'b1;
    end
    if (!it.field_last) return 1'b0;
    res.found     = matched;
    res.truncated = (remaining != 8'd0);
    remaining = 8'd0;
    body_pos  = 8'd0;
    candidate = 1'b0;
    matched   = 1'b0;
    return 1'b1;
  endfunction

  function automatic search_item_t make_load(input logic [7:0] idx, input logic [7:0] data,
                                             input logic last);
    search_item_t it;
    it.op         = OP_LOAD;
    it.word_index = idx;
    it.data_byte  = data;
    it.field_last = last;
    return it;
  endfunction

  function automatic search_item_t make_byte(input logic [7:0] data, input logic last);
    search_item_t it;
    it.op         = OP_BYTE;
    it.word_index = 8'($urandom);
    it.data_byte  = data;
    it.field_last = last;
    return it;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic send_item(input search_item_t it, input bit typed, input search_result_t given);
    int gap;
    search_result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.cmd        <= it.op;
    in_if.word_index <= it.word_index;
    in_if.data_byte  <= it.data_byte;
    in_if.field_last <= it.field_last;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    if (predict_search(it, res)) expected_results.push_back(typed ? given : res);
  endtask

  task automatic settle(input int bound);
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0 && waited < bound) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_word_length(input logic [7:0] value);
    cfg_if.valid       <= 1'b1;
    cfg_if.word_length <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    length_reg = value;
  endtask

  // Most fields are records of the word length whose bodies copy the store,
  // some with one byte changed, some of another length; the final record may
  // be cut short. One field in ten is raw random bytes.
  task automatic build_field();
    int n_rec, r, len, emit, pos, flip, kind;
    logic [7:0] b;
    search_item_t it;
    field_items.delete();
    if ($urandom_range(0, 9) == 0) begin
      n_rec = $urandom_range(1, 6);
      for (r = 0; r < n_rec; r++) field_items.push_back(make_byte(8'($urandom), 1'b0));
    end else begin
      n_rec = (length_reg > 8'd60) ? 1 : $urandom_range(1, 4);
      for (r = 0; r < n_rec; r++) begin
        kind = $urandom_range(0, 9);
        len  = (kind < 7) ? int'(length_reg)
             : $urandom_range(0, (length_reg > 8'd16) ? 20 : int'(length_reg) + 4);
        flip = (kind >= 5 && kind < 7 && len > 0) ? $urandom_range(0, len - 1) : -1;
        emit = len;
        if (r == n_rec - 1 && len > 0 && $urandom_range(0, 4) == 0)
          emit = $urandom_range(0, len - 1);
        field_items.push_back(make_byte(len[7:0], 1'b0));
        for (pos = 0; pos < emit; pos++) begin
          if ($urandom_range(0, 29) == 0)
            field_items.push_back(make_load(8'($urandom), 8'($urandom), 1'($urandom)));
          b = word_set[pos] ? word_mem[pos] : 8'($urandom);
          if (pos == flip) b = b ^ 8'($urandom_range(1, 255));
          field_items.push_back(make_byte(b, 1'b0));
        end
      end
    end
    it = field_items.pop_back();
    it.field_last = 1'b1;
    field_items.push_back(it);
  endtask

  task automatic run_phase(input logic [7:0] wl, input int n_fields, input bit press);
    int i, n_loads;
    settle(SETTLE_BOUND);
    write_word_length(wl);
    if (press) hold_requests++;
    n_loads = $urandom_range(0, 6);
    for (i = 0; i < n_loads; i++)
      send_item(make_load(8'($urandom), 8'($urandom), 1'($urandom)), 1'b0, '0);
    for (i = 0; i < int'(wl); i++)
      if (!word_set[i]) send_item(make_load(i[7:0], 8'($urandom), 1'($urandom)), 1'b0, '0);
    for (i = 0; i < n_fields && items_sent < ITEM_TARGET; i++) begin
      build_field();
      while (field_items.size() != 0) send_item(field_items.pop_front(), 1'b0, '0);
    end
  endtask

  initial begin : result_sink
    logic [15:0] stall_map;
    int          map_age;
    int          hold_served;
    int          held;
    out_if.ready <= 1'b0;
    stall_map   = 16'hFFFF;
    map_age     = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served < hold_requests) begin
        out_if.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_served++;
      end else begin
        if (map_age == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_map = 16'hFFFF;
            1:       stall_map = 16'($urandom) | 16'h0001;
            2:       stall_map = 16'($urandom) | 16'($urandom);
            default: stall_map = (16'($urandom) & 16'($urandom)) | 16'h0001;
          endcase
          map_age = $urandom_range(16, 96);
        end
        out_if.ready <= stall_map[0];
        stall_map = {stall_map[0], stall_map[15:1]};
        map_age--;
      end
    end
  end

  initial begin : result_check
    search_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result found=%0b truncated=%0b",
                                  out_if.found, out_if.truncated));
        end else begin
          want = expected_results.pop_front();
          if (out_if.found !== want.found)
            note_mismatch($sformatf("found: expected %0b, got %0b", want.found, out_if.found));
          if (out_if.truncated !== want.truncated)
            note_mismatch($sformatf("truncated: expected %0b, got %0b",
                                    want.truncated, out_if.truncated));
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("length_prefixed_word_search_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    directed_step_t step;
    search_item_t   it;
    search_result_t given;
    logic [7:0]     wl;
    int             phase_no;
    int             n_fields;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.cmd          <= OP_LOAD;
    in_if.word_index   <= 8'd0;
    in_if.data_byte    <= 8'd0;
    in_if.field_last   <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.word_length <= 8'd0;
    length_reg     = 8'd0;
    remaining      = 8'd0;
    body_pos       = 8'd0;
    candidate      = 1'b0;
    matched        = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    burst_left     = 0;
    hold_requests  = 0;
    foreach (word_set[i]) word_set[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      step = directed_steps[i];
      if (step.kind == STEP_LENGTH) begin
        settle(SETTLE_BOUND);
        write_word_length(step.data);
      end else begin
        it.op              = step.op;
        it.word_index      = step.index;
        it.data_byte       = step.data;
        it.field_last      = step.last;
        given.found        = step.found;
        given.truncated    = step.truncated;
        send_item(it, step.typed, given);
      end
    end

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase_no)
        0:       wl = 8'd0;
        1:       wl = 8'd255;
        2:       wl = 8'd1;
        default: wl = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(11, 60))
                                                  : 8'($urandom_range(0, 10));
      endcase
      n_fields = (wl > 8'd60) ? 2 : $urandom_range(4, 12);
      run_phase(wl, n_fields, phase_no == 3);
      phase_no++;
    end

    settle(SETTLE_BOUND);
    while (expected_results.size() != 0) begin
      given = expected_results.pop_front();
      note_mismatch($sformatf("missing result found=%0b truncated=%0b",
                              given.found, given.truncated));
    end
    if (mismatch_count == 0) begin
      $display("length_prefixed_word_search_tb OK");
    end else begin
      $display("length_prefixed_word_search_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lpws_pkg.sv
rtl/lpws_if.sv
rtl/lpws_front.sv
rtl/lpws_queue.sv
rtl/lpws_back.sv
rtl/length_prefixed_word_search.sv
verif/length_prefixed_word_search_tb.sv
